@@ rtl/core/pvds_pkg.sv @@
// shared types and constants of the particle view depth sorter
`default_nettype none
package pvds_pkg;

   localparam int POS_W                 = 32;
   localparam int VIEW_W                = 16;
   localparam int DEPTH_W               = 34;
   localparam int INDEX_W               = 6;
   localparam int MAX_PARTICLES_DEFAULT = 64;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_CAMERA_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CAMERA_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CAMERA_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_X   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_Y   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_VIEW_Z   = 3'd5;

   localparam logic [VIEW_W-1:0] VIEW_Z_RESET = 16'hC000;

   typedef struct packed {
      logic [POS_W-1:0]  camera_x;
      logic [POS_W-1:0]  camera_y;
      logic [POS_W-1:0]  camera_z;
      logic [VIEW_W-1:0] view_x;
      logic [VIEW_W-1:0] view_y;
      logic [VIEW_W-1:0] view_z;
   } view_cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   typedef struct packed {
      logic      valid;
      logic      final_item;
      logic      store;
      entry_type entry;
   } depth_res_type;

   typedef struct packed {
      logic load;
      logic drain;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/core/pvds_depth.sv @@
// four-stage view depth unit: difference, multiply, sum, magnitude and saturation
`default_nettype none
module pvds_depth
   import pvds_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire view_cfg_type       cfg,
   input  wire logic               in_valid,
   input  wire logic [POS_W-1:0]   pos_x,
   input  wire logic [POS_W-1:0]   pos_y,
   input  wire logic [POS_W-1:0]   pos_z,
   input  wire logic               in_final,
   input  wire logic               in_store,
   input  wire logic [INDEX_W-1:0] in_index,
   output depth_res_type           res
);

   localparam int DIFF_W = POS_W + 1;
   localparam int PROD_W = DIFF_W + VIEW_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SHIFT  = 14;

   typedef struct packed {
      logic               valid;
      logic               final_item;
      logic               store;
      logic [INDEX_W-1:0] index;
   } meta_type;

   meta_type meta1_ff, meta2_ff, meta3_ff, meta4_ff;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         mag;
   logic [DEPTH_W-1:0]       depth_ff, depth_in;

   assign dx_in = $signed({pos_x[POS_W-1], pos_x}) - $signed({cfg.camera_x[POS_W-1], cfg.camera_x});
   assign dy_in = $signed({pos_y[POS_W-1], pos_y}) - $signed({cfg.camera_y[POS_W-1], cfg.camera_y});
   assign dz_in = $signed({pos_z[POS_W-1], pos_z}) - $signed({cfg.camera_z[POS_W-1], cfg.camera_z});

   assign px_in = dx_ff * $signed(cfg.view_x);
   assign py_in = dy_ff * $signed(cfg.view_y);
   assign pz_in = dz_ff * $signed(cfg.view_z);

   assign sum_in = $signed({{2{px_ff[PROD_W-1]}}, px_ff})
                 + $signed({{2{py_ff[PROD_W-1]}}, py_ff})
                 + $signed({{2{pz_ff[PROD_W-1]}}, pz_ff});

   assign mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   // saturate when the shifted magnitude needs more than the depth width
   assign depth_in = (|mag[SUM_W-1:DEPTH_W+SHIFT]) ? {DEPTH_W{1'b1}}
                                                   : mag[DEPTH_W+SHIFT-1:SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff.valid <= 1'b0;
         meta2_ff.valid <= 1'b0;
         meta3_ff.valid <= 1'b0;
         meta4_ff.valid <= 1'b0;
      end else begin
         meta1_ff.valid <= in_valid;
         meta2_ff.valid <= meta1_ff.valid;
         meta3_ff.valid <= meta2_ff.valid;
         meta4_ff.valid <= meta3_ff.valid;
      end
      meta1_ff.final_item <= in_final;
      meta1_ff.store      <= in_store;
      meta1_ff.index      <= in_index;
      meta2_ff.final_item <= meta1_ff.final_item;
      meta2_ff.store      <= meta1_ff.store;
      meta2_ff.index      <= meta1_ff.index;
      meta3_ff.final_item <= meta2_ff.final_item;
      meta3_ff.store      <= meta2_ff.store;
      meta3_ff.index      <= meta2_ff.index;
      meta4_ff.final_item <= meta3_ff.final_item;
      meta4_ff.store      <= meta3_ff.store;
      meta4_ff.index      <= meta3_ff.index;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      dz_ff    <= dz_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      sum_ff   <= sum_in;
      depth_ff <= depth_in;
   end

   assign res.valid       = meta4_ff.valid;
   assign res.final_item  = meta4_ff.final_item;
   assign res.store       = meta4_ff.store;
   assign res.entry.index = meta4_ff.index;
   assign res.entry.depth = depth_ff;

endmodule
`default_nettype wire

@@ rtl/core/pvds_cell.sv @@
// one sorter cell: holds one entry, inserts by shifting down, drains toward the head
`default_nettype none
module pvds_cell
   import pvds_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire entry_type     new_entry,
   input  wire entry_type     prev_entry,
   input  wire logic          prev_take,
   input  wire entry_type     next_entry,
   output entry_type          entry,
   output logic               take
);

   entry_type entry_ff, entry_in;

   // equal depth stays ahead, so earlier loads win ties
   assign take = ctrl.load && (!occupied || (new_entry.depth > entry_ff.depth));

   always_comb begin
      entry_in = entry_ff;
      if (take) begin
         entry_in = prev_take ? prev_entry : new_entry;
      end else if (ctrl.drain) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

@@ rtl/core/particle_view_depth_sort.sv @@
// top level of the particle view depth sorter
// Usage: program camera and view registers on the csr port while idle, then stream
// particle positions on req (one word each, tlast on the last particle of a set).
// Each word is accepted while req_tready is high; its depth comes out of a
// four-stage depth pipeline and is inserted into a chain of MAX_PARTICLES
// sorter cells. Once the tlast word is accepted, req_tready stays low until
// the whole set has been emitted. When the tlast word has left the depth
// pipeline, the set appears on rsp, farthest first, one word per cycle while
// rsp_tready is high. The single sorter chain first loads a set and then
// drains it, so a new set is not taken while one is being emitted.
// rsp_tvalid is driven from the state register; a stall on rsp_tready just
// holds the head word and the chain until it is taken.
// rsp_tlast marks the nearest particle, rsp_tuser flags a set in which particles
// beyond capacity were dropped. Reset clears the fill counts, the overflow flag
// and the registers (view_z resets to -1.0).
`default_nettype none
module particle_view_depth_sort
   import pvds_pkg::*;
#(
   parameter int MAX_PARTICLES = MAX_PARTICLES_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [3*POS_W-1:0]     req_tdata,   // pos_x, pos_y, pos_z
   input  wire logic                   req_tlast,   // final_item
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [INDEX_W+DEPTH_W-1:0]  rsp_tdata,   // particle_index, depth
   output logic                        rsp_tlast,   // end_of_run
   output logic                        rsp_tuser,   // overflowed
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_PARTICLES + 1);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   view_cfg_type  cfg_ff;
   depth_res_type dres;
   cell_ctrl_type ctrl;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          overflow_ff, overflow_in;
   logic          pending_ff, pending_in;
   logic          req_accept, rsp_accept, room;

   entry_type cell_entry [MAX_PARTICLES];
   logic      cell_take  [MAX_PARTICLES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x <= '0;
         cfg_ff.camera_y <= '0;
         cfg_ff.camera_z <= '0;
         cfg_ff.view_x   <= '0;
         cfg_ff.view_y   <= '0;
         cfg_ff.view_z   <= VIEW_Z_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CAMERA_X: cfg_ff.camera_x <= csr_wdata[POS_W-1:0];
            REG_CAMERA_Y: cfg_ff.camera_y <= csr_wdata[POS_W-1:0];
            REG_CAMERA_Z: cfg_ff.camera_z <= csr_wdata[POS_W-1:0];
            REG_VIEW_X:   cfg_ff.view_x   <= csr_wdata[VIEW_W-1:0];
            REG_VIEW_Y:   cfg_ff.view_y   <= csr_wdata[VIEW_W-1:0];
            REG_VIEW_Z:   cfg_ff.view_z   <= csr_wdata[VIEW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !pending_ff;
   assign req_accept = req_tvalid && req_tready;
   assign room       = count_ff < CW'(MAX_PARTICLES);

   pvds_depth u_depth (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (req_accept),
      .pos_x    (req_tdata[POS_W-1:0]),
      .pos_y    (req_tdata[2*POS_W-1:POS_W]),
      .pos_z    (req_tdata[3*POS_W-1:2*POS_W]),
      .in_final (req_tlast),
      .in_store (room),
      .in_index (INDEX_W'(count_ff)),
      .res      (dres)
   );

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign ctrl.load  = dres.valid && dres.store;
   assign ctrl.drain = rsp_accept;

   for (genvar i = 0; i < MAX_PARTICLES; i++) begin : g_cell
      entry_type prev_entry, next_entry;
      logic      prev_take;
      if (i == 0) begin : g_head
         assign prev_entry = dres.entry;
         assign prev_take  = 1'b0;
      end else begin : g_body
         assign prev_entry = cell_entry[i-1];
         assign prev_take  = cell_take[i-1];
      end
      if (i == MAX_PARTICLES - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end
      pvds_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (CW'(i) < fill_ff),
         .new_entry  (dres.entry),
         .prev_entry (prev_entry),
         .prev_take  (prev_take),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .take       (cell_take[i])
      );
   end

   assign rsp_tdata = {cell_entry[0].depth, cell_entry[0].index};
   assign rsp_tlast = (fill_ff == CW'(1));
   assign rsp_tuser = overflow_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      pending_in  = pending_ff;
      if (req_accept) begin
         if (room) begin
            count_in = count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
         if (req_tlast) begin
            pending_in = 1'b1;
         end
      end
      if (ctrl.load) begin
         fill_in = fill_ff + CW'(1);
      end
      case (state_ff)
         ST_LOAD: begin
            if (dres.valid && dres.final_item) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_accept) begin
               fill_in = fill_ff - CW'(1);
               // last word of the set: back to loading
               if (fill_ff == CW'(1)) begin
                  state_in    = ST_LOAD;
                  count_in    = '0;
                  overflow_in = 1'b0;
                  pending_in  = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         fill_ff     <= '0;
         overflow_ff <= 1'b0;
         pending_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         fill_ff     <= fill_in;
         overflow_ff <= overflow_in;
         pending_ff  <= pending_in;
      end
   end

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fill_ff != '0))
      else $error("emitting from an empty sorter chain");

   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input open while a set is being emitted");

   a_fill_le_count: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= count_ff)
      else $error("more cells filled than particles loaded");

   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_tlast) |=> (count_ff == '0 && fill_ff == '0 && !overflow_ff))
      else $error("set state not cleared after the last word");

endmodule
`default_nettype wire
